>>> rtl/core/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types and constants of the biquad filter: widths, the coefficient
// register map, the multiplier operand codes and the command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bqd_pkg;

  localparam int unsigned SAMPLE_WIDTH   = 24;
  localparam int unsigned COEF_WIDTH     = 32;
  localparam int unsigned COEF_FRAC_BITS = 28;
  localparam int unsigned STATE_WIDTH    = 48;
  localparam int unsigned NUM_COEFS      = 5;

  localparam int unsigned STATE_FRAC = STATE_WIDTH - SAMPLE_WIDTH - 8;
  localparam int unsigned PROD_SHIFT = COEF_FRAC_BITS - STATE_FRAC;
  localparam int unsigned PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int unsigned RP_WIDTH   = PROD_WIDTH - PROD_SHIFT + 1;
  localparam int unsigned SUM_WIDTH  = STATE_WIDTH + 2;
  localparam int unsigned YR_WIDTH   = STATE_WIDTH - STATE_FRAC + 1;

  localparam int unsigned ADDR_WIDTH = 5;
  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;

  typedef logic [COEF_WIDTH-1:0] coef_t;
  typedef coef_t [NUM_COEFS-1:0] coef_arr_t;

  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_B0_IN = 3'd0,
    MUL_B1_X  = 3'd1,
    MUL_B2_X  = 3'd2,
    MUL_A1_Y  = 3'd3,
    MUL_A2_Y  = 3'd4
  } mul_op_e;

  typedef struct packed {
    logic    x_en;
    logic    mul_en;
    mul_op_e mul_op;
    logic    acc_en;
    logic    y_en;
    logic    f1_en;
    logic    f2_en;
    logic    d1_en;
    logic    d2_en;
    logic    out_en;
  } bqd_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/bqd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bqd_cfg_regs
// APB-style coefficient register file with read-back of all five registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqd_cfg_regs
  import bqd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready,
  output coef_arr_t                  coefs_o
);

  coef_arr_t coef_q;
  coef_arr_t coef_d;
  logic      wr_en;
  reg_idx_e  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_WIDTH-1:2]);

  always_comb begin
    coef_d = coef_q;
    if (wr_en) begin
      case (idx)
        REG_B0:  coef_d[REG_B0] = pwdata;
        REG_B1:  coef_d[REG_B1] = pwdata;
        REG_B2:  coef_d[REG_B2] = pwdata;
        REG_A1:  coef_d[REG_A1] = pwdata;
        REG_A2:  coef_d[REG_A2] = pwdata;
        default: coef_d = coef_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_B0:  prdata = coef_q[REG_B0];
      REG_B1:  prdata = coef_q[REG_B1];
      REG_B2:  prdata = coef_q[REG_B2];
      REG_A1:  prdata = coef_q[REG_A1];
      REG_A2:  prdata = coef_q[REG_A2];
      default: prdata = '0;
    endcase
  end

  // The b0 register sits in the lowest slice and resets to 1.0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= {{((NUM_COEFS-1)*COEF_WIDTH){1'b0}}, COEF_ONE};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coefs_o = coef_q;

endmodule

`default_nettype wire

>>> rtl/core/bqd_ctrl.sv
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer that steps one sample through the shared multiplier and owns
// the input stall and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqd_ctrl
  import bqd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output bqd_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_OUT  = 6'b000100,
    ST_MA1  = 6'b001000,
    ST_MA2  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    cmd_o.mul_op = MUL_B0_IN;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.x_en   = 1'b1;
          cmd_o.mul_en = 1'b1;
          state_d      = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_B1_X;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.y_en   = 1'b1;
        cmd_o.f1_en  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_B2_X;
        state_d      = ST_MA1;
      end
      ST_MA1: begin
        cmd_o.f2_en  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_A1_Y;
        state_d      = ST_MA2;
      end
      ST_MA2: begin
        cmd_o.d1_en  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_A2_Y;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.d2_en  = 1'b1;
          cmd_o.out_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/bqd_datapath.sv
// ----------------------------------------------------------------------------
// bqd_datapath
// Shared 32x24 multiplier, rounding and saturating adders, the two delay
// states and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqd_datapath
  import bqd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bqd_cmd_t                cmd_i,
  input  wire coef_arr_t               coefs_i,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic      [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                         clipped_o
);

  function automatic logic [SUM_WIDTH-1:0] ext_rp(input logic [RP_WIDTH-1:0] v);
    ext_rp = {{(SUM_WIDTH - RP_WIDTH){v[RP_WIDTH-1]}}, v};
  endfunction

  function automatic logic [SUM_WIDTH-1:0] ext_st(input logic [STATE_WIDTH-1:0] v);
    ext_st = {{(SUM_WIDTH - STATE_WIDTH){v[STATE_WIDTH-1]}}, v};
  endfunction

  function automatic logic [STATE_WIDTH-1:0] sat_state(input logic [SUM_WIDTH-1:0] v);
    logic [SUM_WIDTH-STATE_WIDTH:0] top;
    top = v[SUM_WIDTH-1:STATE_WIDTH-1];
    if (top == '0 || top == '1) begin
      sat_state = v[STATE_WIDTH-1:0];
    end else if (v[SUM_WIDTH-1]) begin
      sat_state = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      sat_state = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
  endfunction

  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [PROD_WIDTH-1:0]   mul_res;
  logic        [PROD_WIDTH-1:0]   p_q;
  logic        [RP_WIDTH-1:0]     rp;
  logic        [SAMPLE_WIDTH-1:0] x_q;
  logic        [STATE_WIDTH-1:0]  acc_q;
  logic        [SAMPLE_WIDTH-1:0] y_q;
  logic                           clip_q;
  logic        [SUM_WIDTH-1:0]    f1_q;
  logic        [SUM_WIDTH-1:0]    f2_q;
  logic        [STATE_WIDTH-1:0]  d1_q;
  logic        [STATE_WIDTH-1:0]  d2_q;
  logic        [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                           clipped_q;
  logic        [YR_WIDTH-1:0]     yr;
  logic        [YR_WIDTH-SAMPLE_WIDTH:0] yr_top;
  logic        [SAMPLE_WIDTH-1:0] y_d;
  logic                           clip_d;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_B0_IN: begin
        mul_a = coefs_i[REG_B0];
        mul_b = sample_in_i;
      end
      MUL_B1_X: begin
        mul_a = coefs_i[REG_B1];
        mul_b = x_q;
      end
      MUL_B2_X: begin
        mul_a = coefs_i[REG_B2];
        mul_b = x_q;
      end
      MUL_A1_Y: begin
        mul_a = coefs_i[REG_A1];
        mul_b = y_q;
      end
      MUL_A2_Y: begin
        mul_a = coefs_i[REG_A2];
        mul_b = y_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  assign rp = {p_q[PROD_WIDTH-1], p_q[PROD_WIDTH-1:PROD_SHIFT]}
            + RP_WIDTH'(p_q[PROD_SHIFT-1]);

  assign yr = {acc_q[STATE_WIDTH-1], acc_q[STATE_WIDTH-1:STATE_FRAC]}
            + YR_WIDTH'(acc_q[STATE_FRAC-1]);
  assign yr_top = yr[YR_WIDTH-1:SAMPLE_WIDTH-1];

  always_comb begin
    if (yr_top == '0 || yr_top == '1) begin
      y_d    = yr[SAMPLE_WIDTH-1:0];
      clip_d = 1'b0;
    end else if (yr[YR_WIDTH-1]) begin
      y_d    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      clip_d = 1'b1;
    end else begin
      y_d    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_en) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.mul_en) begin
      p_q <= mul_res;
    end
    if (cmd_i.acc_en) begin
      acc_q <= sat_state(ext_rp(rp) + ext_st(d1_q));
    end
    if (cmd_i.y_en) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
    if (cmd_i.f1_en) begin
      f1_q <= ext_rp(rp) + ext_st(d2_q);
    end
    if (cmd_i.f2_en) begin
      f2_q <= ext_rp(rp);
    end
    if (cmd_i.out_en) begin
      sample_out_q <= y_q;
      clipped_q    <= clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      if (cmd_i.d1_en) begin
        d1_q <= sat_state(f1_q - ext_rp(rp));
      end
      if (cmd_i.d2_en) begin
        d2_q <= sat_state(f2_q - ext_rp(rp));
      end
    end
  end

  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

`default_nettype wire

>>> rtl/core/biquad_iir_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Second-order IIR filter in transposed direct form II with Q4.28
// coefficients, 48-bit delay states and a saturated 24-bit output.
//
// The input channel takes one signed 24-bit sample per beat, and the output
// channel gives one filtered sample with its clip flag per beat. Both use
// valid and stall; a beat moves when valid is high and stall is low.
// One shared 32x24 multiplier forms the five products in turn, so the block
// works on one sample at a time; the input stall is high from each input
// beat until that sample's last step, so no new sample is taken before it.
// The output register holds a finished sample while the receiver stalls;
// the next sample is still taken and computed, and its last step waits
// until the output register is free, which holds the input stall high.
// Reset clears both delay states, empties the output register and loads a
// pass-through setting (b0 = 1.0, all other coefficients zero). Coefficients
// are written over the APB-style port, b0, b1, b2, a1, a2 at byte addresses
// 0, 4, 8, 12 and 16; the user writes them only while no sample is in
// flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter_unit
  import bqd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_WIDTH-1:0]   paddr,
  input  wire logic [DATA_WIDTH-1:0]   pwdata,
  output logic      [DATA_WIDTH-1:0]   prdata,
  output logic                         pready,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                         clipped_o
);

  coef_arr_t coefs;
  bqd_cmd_t  cmd;

  bqd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs_o (coefs)
  );

  bqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bqd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .coefs_i      (coefs),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the biquad filter unit. The coefficients are loaded
// over the register port and read back. Samples are sent under random sender
// and receiver idling. Each output beat is compared with a fixed-point
// transposed direct form II filter kept in this file. The directed tests cover
// pass-through, rounding, clipping and writes to an unused address. A long
// receiver hold-off fills the block, and random phases then sweep several
// coefficient sets, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bqd_pkg::*;

  localparam int unsigned REG_STRIDE        = 4;
  localparam int unsigned SPARE_IDX         = NUM_COEFS;
  localparam int unsigned ITEMS_PER_SETTING = 125;
  localparam int unsigned HOLD_CYCLES       = 200;
  localparam int unsigned DRAIN_LIMIT       = 5000;
  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS       = 10;

  localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMP_ONE = SAMPLE_WIDTH'(1);
  localparam logic [SAMPLE_WIDTH-1:0] SMP_NEG = {SAMPLE_WIDTH{1'b1}};

  localparam coef_t COEF_MAX  = 32'h7FFF_FFFF;
  localparam coef_t COEF_MIN  = 32'h8000_0000;
  localparam coef_t COEF_HALF = 32'h0800_0000;
  localparam coef_t COEF_ZERO = 32'h0000_0000;
  localparam coef_t LP_B0     = 32'h0400_0000;
  localparam coef_t LP_B1     = 32'h0800_0000;
  localparam coef_t LP_B2     = 32'h0400_0000;
  localparam coef_t LP_A1     = 32'hF199_999A;
  localparam coef_t LP_A2     = 32'h0666_6666;

  localparam longint LONG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LONG_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    clip;
  } filt_out_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [ADDR_WIDTH-1:0]   paddr       = '0;
  logic [DATA_WIDTH-1:0]   pwdata      = '0;
  logic [DATA_WIDTH-1:0]   prdata;
  logic                    pready;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [SAMPLE_WIDTH-1:0] sample_in_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [SAMPLE_WIDTH-1:0] sample_out_o;
  logic                    clipped_o;

  coef_t       coef_shadow [NUM_COEFS];
  longint      z1;
  longint      z2;
  filt_out_t   expected_out [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_taken    = 0;
  int unsigned hold_left      = 0;

  biquad_iir_filter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %h, actual %h", what, exp_v, act_v);
    end
  endfunction

  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? LONG_MIN : LONG_MAX;
    return s;
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    longint s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? LONG_MIN : LONG_MAX;
    return s;
  endfunction

  function automatic longint round_shift(longint v, int unsigned sh);
    return add_sat(v, longint'(1) <<< (sh - 1)) >>> sh;
  endfunction

  function automatic longint clamp_to(longint v, int unsigned w, output bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint coef_mul(coef_t c, longint s);
    return round_shift(longint'(signed'(c)) * s, PROD_SHIFT);
  endfunction

  // One step of the filter: output from the first delay, then both delays.
  function automatic filt_out_t filter_sample(logic [SAMPLE_WIDTH-1:0] x_bits);
    longint    x;
    longint    acc;
    longint    y;
    bit        clip;
    bit        unused_hit;
    filt_out_t r;
    x   = longint'(signed'(x_bits));
    acc = clamp_to(add_sat(coef_mul(coef_shadow[REG_B0], x), z1), STATE_WIDTH, unused_hit);
    y   = clamp_to(round_shift(acc, STATE_FRAC), SAMPLE_WIDTH, clip);
    z1  = clamp_to(add_sat(sub_sat(coef_mul(coef_shadow[REG_B1], x),
                                   coef_mul(coef_shadow[REG_A1], y)), z2),
                   STATE_WIDTH, unused_hit);
    z2  = clamp_to(sub_sat(coef_mul(coef_shadow[REG_B2], x),
                           coef_mul(coef_shadow[REG_A2], y)),
                   STATE_WIDTH, unused_hit);
    r.sample = y[SAMPLE_WIDTH-1:0];
    r.clip   = clip;
    return r;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SAMPLE_WIDTH'($urandom_range(511)) - SAMPLE_WIDTH'(256);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Output side: random stall, long hold-offs on request, and the result check.
  always @(posedge clk_i) begin : result_check
    filt_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_out.size() == 0) begin
        note_mismatch("output beat with nothing expected", '0, 32'(sample_out_o));
      end else begin
        want = expected_out.pop_front();
        if (sample_out_o !== want.sample) begin
          note_mismatch("sample_out", 32'(want.sample), 32'(sample_out_o));
        end
        if (clipped_o !== want.clip) begin
          note_mismatch("clipped", 32'(want.clip), 32'(clipped_o));
        end
      end
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      holds_taken <= holds_taken + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_sample(logic [SAMPLE_WIDTH-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    expected_out.push_back(filter_sample(x));
  endtask

  task automatic drain();
    int unsigned n;
    n = 0;
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (expected_out.size() != 0) begin
      note_mismatch("output beats missing", 32'(expected_out.size()), '0);
      expected_out.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_access(bit wr, int unsigned idx, coef_t wdata, output coef_t rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_WIDTH'(idx * REG_STRIDE);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr && idx < NUM_COEFS) coef_shadow[idx] = wdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
    coef_t vals [NUM_COEFS];
    coef_t rd;
    vals[REG_B0] = b0;
    vals[REG_B1] = b1;
    vals[REG_B2] = b2;
    vals[REG_A1] = a1;
    vals[REG_A2] = a2;
    for (int i = 0; i < NUM_COEFS; i++) reg_access(1'b1, i, vals[i], rd);
    for (int i = 0; i < NUM_COEFS; i++) begin
      reg_access(1'b0, i, '0, rd);
      if (rd !== coef_shadow[i]) note_mismatch("coefficient readback", coef_shadow[i], rd);
    end
  endtask

  task automatic test_passthrough();
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    send_sample(SMP_ONE);
    send_sample(SMP_NEG);
    drain();
  endtask

  task automatic test_rounding();
    load_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    send_sample(SMP_ONE);
    send_sample(SMP_NEG);
    send_sample(SAMPLE_WIDTH'(3));
    send_sample(-SAMPLE_WIDTH'(3));
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    drain();
  endtask

  task automatic test_clipping();
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample('0);
    send_sample('0);
    send_sample(SMP_MIN);
    drain();
  endtask

  task automatic test_spare_register();
    coef_t rd;
    load_coefs(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
    reg_access(1'b1, SPARE_IDX, COEF_MAX, rd);
    send_sample(SMP_MAX);
    send_sample(SMP_ONE);
    send_sample(SMP_MIN);
    send_sample('0);
    drain();
  endtask

  // The receiver holds off while samples keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    repeat (24) send_sample(pick_sample());
    drain();
  endtask

  task automatic test_random_phase(int unsigned s_pct, int unsigned r_pct);
    coef_t c [NUM_COEFS];
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: begin
          c[REG_B0] = LP_B0;
          c[REG_B1] = LP_B1;
          c[REG_B2] = LP_B2;
          c[REG_A1] = LP_A1;
          c[REG_A2] = LP_A2;
        end
        1: foreach (c[i]) c[i] = COEF_MAX;
        2: foreach (c[i]) c[i] = COEF_MIN;
        3: foreach (c[i]) c[i] = $urandom;
        default: begin
          c[REG_B0] = $urandom_range(32'h2000_0000) - 32'h1000_0000;
          c[REG_B1] = $urandom_range(32'h2000_0000) - 32'h1000_0000;
          c[REG_B2] = $urandom_range(32'h2000_0000) - 32'h1000_0000;
          c[REG_A1] = $urandom_range(32'h1000_0000) - 32'h0800_0000;
          c[REG_A2] = $urandom_range(32'h1000_0000) - 32'h0800_0000;
        end
      endcase
      load_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A1], c[REG_A2]);
      repeat (ITEMS_PER_SETTING) send_sample(pick_sample());
      drain();
    end
  endtask

  initial begin
    coef_shadow[REG_B0] = COEF_ONE;
    coef_shadow[REG_B1] = COEF_ZERO;
    coef_shadow[REG_B2] = COEF_ZERO;
    coef_shadow[REG_A1] = COEF_ZERO;
    coef_shadow[REG_A2] = COEF_ZERO;
    z1 = 0;
    z2 = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_rounding();
    test_clipping();
    test_spare_register();
    test_backpressure();
    test_random_phase(30, 62);
    test_random_phase(62, 30);
    test_random_phase(0, 0);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bqd_pkg.sv
rtl/core/bqd_cfg_regs.sv
rtl/core/bqd_ctrl.sv
rtl/core/bqd_datapath.sv
rtl/core/biquad_iir_filter_unit.sv
sim/testbench.sv
